[rtl/wdia_pkg.sv]
// ----------------------------------------------------------------------------
// wdia_pkg
// Shared types and constants of the windowed distinct-tag alarm unit.
// ----------------------------------------------------------------------------
package wdia_pkg;

    // Default sizes handed to the top level
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int MAX_LIMIT_DEF     = 15;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int TAG_W    = 16;
    localparam int USER_W   = 16;
    localparam int WINDOW_W = 17;
    localparam int LIMIT_W  = 4;
    localparam int FOUND_W  = 5;

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 17'd3600;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd3;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // take request, write ring, seed distinct set
        logic step;   // consume one older ring entry
        logic emit;   // move finished result into output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_end;  // no more entries, or entry outside window
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

endpackage

[rtl/wdia_ctrl.sv]
// ----------------------------------------------------------------------------
// wdia_ctrl
// Sequencer: accept one request, walk the history, hand result to output.
// ----------------------------------------------------------------------------
module wdia_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  wdia_pkg::dp_status_t   status,
    output wdia_pkg::ctrl_cmd_t    cmd
);
    import wdia_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (status.walk_end && status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_WALK: begin
                cmd.step = !status.walk_end;
                cmd.emit = status.walk_end && status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/wdia_datapath.sv]
// ----------------------------------------------------------------------------
// wdia_datapath
// Event ring, window compare, distinct-tag lanes and output register.
// ----------------------------------------------------------------------------
module wdia_datapath #(
    parameter int HISTORY_DEPTH = wdia_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_LIMIT     = wdia_pkg::MAX_LIMIT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [wdia_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wdia_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [wdia_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  wdia_pkg::ctrl_cmd_t                 cmd,
    output wdia_pkg::dp_status_t                status,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [wdia_pkg::M_TDATA_W-1:0]      m_tdata
);
    import wdia_pkg::*;

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int FW     = $clog2(HISTORY_DEPTH + 2);
    localparam int SEEN_N = MAX_LIMIT + 1;
    localparam int CW     = $clog2(MAX_LIMIT + 2);
    localparam int LW     = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int ENT_W  = TIME_W + TAG_W;

    localparam logic [AW-1:0] SLOT_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);

    // config
    logic [WINDOW_W-1:0] window_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // ring state
    logic [ENT_W-1:0]    hist_mem [HISTORY_DEPTH];
    logic [AW-1:0]       wr_slot_reg, wr_slot_next;
    logic [FW-1:0]       fill_reg, fill_next;

    // current item
    logic [TIME_W-1:0]   time_reg;
    logic [USER_W-1:0]   user_reg;

    // walk
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [ENT_W-1:0]    rd_data_reg;
    logic [AW-1:0]       remain_reg, remain_next;
    logic [TAG_W-1:0]    seen_tag_reg [SEEN_N];
    logic [CW-1:0]       seen_count_reg;

    // output register
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [TIME_W-1:0]   in_time;
    logic [TAG_W-1:0]    in_tag;
    logic [USER_W-1:0]   in_user;
    logic [AW-1:0]       slot;
    logic [FW-1:0]       fill_base;
    logic [FW-1:0]       stored;
    logic [TIME_W-1:0]   rd_time;
    logic [TAG_W-1:0]    rd_tag;
    logic                out_win;
    logic                tag_hit;
    logic                do_insert;
    logic [LW-1:0]       limit_eff;
    logic                boundary;
    logic                truncated;
    logic                alarm;

    assign in_time = s_tdata[TIME_W-1:0];
    assign in_tag  = s_tdata[TIME_W+TAG_W-1:TIME_W];
    assign in_user = s_tdata[TIME_W+TAG_W+USER_W-1:TIME_W+TAG_W];

    assign rd_time = rd_data_reg[ENT_W-1:TAG_W];
    assign rd_tag  = rd_data_reg[TAG_W-1:0];

    // limit clamped to MAX_LIMIT, one below the lane count
    assign limit_eff = (LW'(limit_reg) > LW'(MAX_LIMIT)) ? LW'(MAX_LIMIT) : LW'(limit_reg);

    // ---- config registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WINDOW: window_reg <= cfg_data[WINDOW_W-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    // ---- ring pointers on load, read pointer also on step ----
    always_comb begin
        slot      = s_tuser ? '0 : wr_slot_reg;
        fill_base = s_tuser ? '0 : fill_reg;
        wr_slot_next = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
        fill_next    = (fill_base <= FILL_FULL) ? fill_base + 1'b1 : fill_base;
        stored       = (fill_next < FILL_FULL) ? fill_next : FILL_FULL;

        rd_addr_next = rd_addr_reg;
        remain_next  = remain_reg;
        if (cmd.load) begin
            // newest older entry sits just behind the slot written now
            rd_addr_next = (slot == '0) ? SLOT_LAST : slot - 1'b1;
            remain_next  = AW'(stored - 1'b1);
        end else if (cmd.step) begin
            rd_addr_next = (rd_addr_reg == '0) ? SLOT_LAST : rd_addr_reg - 1'b1;
            remain_next  = remain_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_slot_reg <= '0;
            fill_reg    <= '0;
        end else if (cmd.load) begin
            wr_slot_reg <= wr_slot_next;
            fill_reg    <= fill_next;
        end
    end

    // ---- history memory: one write, one registered read ----
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hist_mem[slot] <= {in_time, in_tag};
        end
        rd_data_reg <= hist_mem[rd_addr_next];
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        if (cmd.load) begin
            time_reg <= in_time;
            user_reg <= in_user;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
        end else begin
            remain_reg <= remain_next;
        end
    end

    // ---- window and distinct-set compare ----
    assign out_win = (time_reg > rd_time) &&
                     ((time_reg - rd_time) > TIME_W'(window_reg));

    always_comb begin
        tag_hit = 1'b0;
        for (int i = 0; i < SEEN_N; i++) begin
            if ((CW'(i) < seen_count_reg) && (seen_tag_reg[i] == rd_tag)) begin
                tag_hit = 1'b1;
            end
        end
    end

    assign do_insert = cmd.step && !tag_hit && (LW'(seen_count_reg) <= limit_eff);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < SEEN_N; i++) begin
            if (cmd.load && i == 0) begin
                seen_tag_reg[i] <= in_tag;
            end else if (do_insert && seen_count_reg == CW'(i)) begin
                seen_tag_reg[i] <= rd_tag;
            end
        end
    end

    // current event always counts as one distinct tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_count_reg <= '0;
        end else if (cmd.load) begin
            seen_count_reg <= CW'(1);
        end else if (do_insert) begin
            seen_count_reg <= seen_count_reg + 1'b1;
        end
    end

    assign status.walk_end = (remain_reg == '0) || out_win;
    assign status.out_free = !m_tvalid_reg || m_tready;

    // ---- result ----
    assign boundary  = out_win && (remain_reg != '0);
    assign truncated = !boundary && (fill_reg > FILL_FULL);
    assign alarm     = LW'(seen_count_reg) > limit_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {1'b0, truncated, alarm, FOUND_W'(seen_count_reg),
                            time_reg, user_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- checks ----
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL + 1'b1)
        else $error("fill count above saturation");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_slot_reg <= SLOT_LAST)
        else $error("write slot outside ring");

    a_step_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (remain_reg != '0) && !out_win)
        else $error("step without an entry in window");

    a_load_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (seen_count_reg == CW'(1)) && (remain_reg < AW'(HISTORY_DEPTH - 1) ||
                                                   remain_reg == SLOT_LAST))
        else $error("distinct set not seeded on load");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid_reg && (m_tdata_reg[FOUND_W+TIME_W+USER_W-1:TIME_W+USER_W] != '0))
        else $error("emitted result missing or with empty count");

endmodule

[rtl/windowed_distinct_id_alarm_unit.sv]
// ----------------------------------------------------------------------------
// windowed_distinct_id_alarm_unit
// Sliding-window distinct device-tag counter with alarm, per user group.
// ----------------------------------------------------------------------------
// Walk: after a request is taken, the ring entries held for the group are
//   read back one entry per cycle until the window closes or they run out.
// A new request is taken only once the result of the last one has moved
//   into the output register.
// Reset (aresetn low, synchronous): empty history, no result pending,
//   window 3600 s, limit 3. Ring contents are not cleared; no clearing pass.
// ----------------------------------------------------------------------------
module windowed_distinct_id_alarm_unit #(
    parameter int HISTORY_DEPTH = wdia_pkg::HISTORY_DEPTH_DEF,  // 2..256
    parameter int MAX_LIMIT     = wdia_pkg::MAX_LIMIT_DEF       // 1..63
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration writes; index 0 window_seconds, 1 device_limit
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wdia_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wdia_pkg::CFG_DATA_W-1:0]     cfg_data,

    // event requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] event_time, [47:32] device_tag, [63:48] user_key
    input  logic [wdia_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] new_group
    input  logic                                s_tuser,

    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] user_out, [47:16] time_out, [52:48] distinct_found,
    // [53] alarm, [54] history_truncated, [55] zero
    output logic [wdia_pkg::M_TDATA_W-1:0]      m_tdata
);
    import wdia_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // config registers are plain flops, always writable
    assign cfg_ready = 1'b1;

    // sequencer: IDLE takes a request, WALK steps the ring until the window
    // closes or the group's entries run out, then hands over to the output
    // register (which may still hold the previous result)
    wdia_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // ring memory, compare lanes for the distinct set, output register
    wdia_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_LIMIT     (MAX_LIMIT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed distinct-tag alarm unit. Event requests
// go in on the slave stream and results are taken from the master stream, both
// with random idle and stall cycles. A behavioural copy of the history ring
// and the distinct-tag walk predicts every result, and each result is checked
// field by field in arrival order. Directed cases come first, then random
// per-user groups under several window and limit settings.
// ----------------------------------------------------------------------------
module tb;
    import wdia_pkg::*;

    localparam int HIST_DEPTH   = HISTORY_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int EVENT_TARGET = 1050;

    // indexes with no register behind them; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic               pad;
        logic               truncated;
        logic               alarm;
        logic [FOUND_W-1:0] found;
        logic [TIME_W-1:0]  stamp;
        logic [USER_W-1:0]  user;
    } alarm_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    // predictor state: registers and the ring of the current group
    logic [WINDOW_W-1:0] win_reg;
    logic [LIMIT_W-1:0]  lim_reg;
    logic [TIME_W-1:0]   ring_time [0:HIST_DEPTH-1];
    logic [TAG_W-1:0]    ring_tag  [0:HIST_DEPTH-1];
    int                  ring_fill;
    int                  ring_slot;

    alarm_result_t pending_alarms [$];
    int            fault_count;
    int            events_sent;
    logic          no_gaps;

    windowed_distinct_id_alarm_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL windowed_distinct_id_alarm_unit");
        $finish;
    end

    // Store the event, then walk back from it while the gap stays inside the
    // window, collecting distinct tags up to limit + 1.
    task automatic predict_distinct(input logic [TIME_W-1:0] stamp,
                                    input logic [TAG_W-1:0] tag,
                                    input logic [USER_W-1:0] user,
                                    input logic ng);
        logic [TAG_W-1:0]  distinct_tags [0:MAX_LIMIT_DEF];
        logic [TIME_W-1:0] span;
        logic              boundary;
        logic              known;
        int                count;
        int                walk_len;
        int                idx;
        int                k;
        int                j;
        alarm_result_t     r;
        if (ng) begin
            ring_fill = 0;
            ring_slot = 0;
        end
        ring_time[ring_slot] = stamp;
        ring_tag[ring_slot]  = tag;
        ring_slot = (ring_slot + 1) % HIST_DEPTH;
        if (ring_fill <= HIST_DEPTH)
            ring_fill++;
        walk_len = (ring_fill < HIST_DEPTH) ? ring_fill : HIST_DEPTH;
        count    = 0;
        boundary = 1'b0;
        idx      = ring_slot;
        for (k = 0; k < walk_len && !boundary; k++) begin
            idx  = (idx + HIST_DEPTH - 1) % HIST_DEPTH;
            // stored time ahead of the current one counts as no gap
            span = (stamp >= ring_time[idx]) ? stamp - ring_time[idx] : '0;
            if (span > TIME_W'(win_reg)) begin
                boundary = 1'b1;
            end else begin
                known = 1'b0;
                for (j = 0; j < count; j++)
                    if (distinct_tags[j] == ring_tag[idx])
                        known = 1'b1;
                if (!known && count < int'(lim_reg) + 1) begin
                    distinct_tags[count] = ring_tag[idx];
                    count++;
                end
            end
        end
        r.pad       = 1'b0;
        r.truncated = !boundary && ring_fill > HIST_DEPTH;
        r.alarm     = count > int'(lim_reg);
        r.found     = count[FOUND_W-1:0];
        r.stamp     = stamp;
        r.user      = user;
        pending_alarms.push_back(r);
    endtask

    // One request; valid is left high on acceptance so that a following
    // request with no idle cycle runs back to back.
    task automatic send_event(input logic [TIME_W-1:0] stamp,
                              input logic [TAG_W-1:0] tag,
                              input logic [USER_W-1:0] user,
                              input logic ng);
        int hold_off;
        hold_off = no_gaps ? 0 : $urandom_range(0, 4);
        if (hold_off > 0) begin
            s_tvalid <= 1'b0;
            repeat (hold_off) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {user, tag, stamp};
        s_tuser  <= ng;
        do @(posedge aclk); while (!s_tready);
        predict_distinct(stamp, tag, user, ng);
        events_sent++;
    endtask

    // Drop valid and wait until every predicted result has been taken.
    task automatic await_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_alarms.size() != 0);
    endtask

    // Only called with the block idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WINDOW: win_reg = data;
            CFG_LIMIT:  lim_reg = data[LIMIT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        fault_count++;
    endtask

    // Result side: check each accepted result, then drop ready at random unless no_gaps is set.
    initial begin : receive_results
        alarm_result_t got;
        alarm_result_t want;
        int            stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_alarms.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, got 0x%0h",
                             $time, got);
                    fault_count++;
                end else begin
                    want = pending_alarms.pop_front();
                    if (got.user !== want.user)
                        report_field("user_out", 32'(want.user), 32'(got.user));
                    if (got.stamp !== want.stamp)
                        report_field("time_out", want.stamp, got.stamp);
                    if (got.found !== want.found)
                        report_field("distinct_found", 32'(want.found), 32'(got.found));
                    if (got.alarm !== want.alarm)
                        report_field("alarm", 32'(want.alarm), 32'(got.alarm));
                    if (got.truncated !== want.truncated)
                        report_field("history_truncated", 32'(want.truncated),
                                     32'(got.truncated));
                    if (got.pad !== want.pad)
                        report_field("padding", 32'(want.pad), 32'(got.pad));
                end
                stall = no_gaps ? 0 : $urandom_range(0, 4);
            end else if (stall > 0) begin
                stall--;
            end
            m_tready <= (stall == 0);
        end
    end

    // A user's group: new_group on the first event (mostly), times moving
    // forward in steps scaled to the window, tags from a small pool so that
    // repeats occur. About one event in twelve is disturbed.
    task automatic run_user_group(input int len, input logic fresh);
        logic [TIME_W-1:0] stamp;
        logic [TAG_W-1:0]  tag;
        logic [TAG_W-1:0]  base;
        logic [USER_W-1:0] user;
        logic              ng;
        int                pool;
        int                k;
        user  = USER_W'($urandom);
        stamp = $urandom;
        base  = TAG_W'($urandom);
        pool  = $urandom_range(1, 20);
        for (k = 0; k < len; k++) begin
            ng  = (k == 0) ? fresh : 1'b0;
            tag = TAG_W'(base + $urandom_range(0, pool - 1));
            if (k > 0) begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: stamp = stamp + $urandom_range(0, win_reg);
                    2: stamp = stamp + $urandom_range(0, win_reg / 8 + 1);
                    default: stamp = stamp + win_reg + $urandom_range(0, 2);
                endcase
            end
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 2))
                    0: stamp = stamp - $urandom_range(1, 200000);  // goes back in time
                    1: ng = 1'b1;                                  // group restarts early
                    default: tag = TAG_W'($urandom);
                endcase
            end
            send_event(stamp, tag, user, ng);
        end
    endtask

    task automatic test_default_window();
        // reset settings: window 3600 s, limit 3; first event has no new_group
        send_event(32'd100, 16'h0005, 16'h0000, 1'b0);
        send_event(32'd100, 16'h0005, 16'h0000, 1'b0);
        send_event(32'd3700, 16'h0007, 16'h0000, 1'b0);     // gap equals window
        send_event(32'd3701, 16'h0009, 16'h0000, 1'b0);     // one past window
        send_event(32'd3000, 16'hFFFF, 16'h0000, 1'b0);     // earlier than stored: alarm
        send_event(32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 1'b1);
        send_event(32'h0000_0000, 16'h0001, 16'hFFFF, 1'b0);
        send_event(32'hFFFF_FFFF, 16'h0002, 16'hFFFF, 1'b0); // huge gap to previous
        await_results();
    endtask

    task automatic test_zero_limit_window();
        // limit zero: cap of one, alarm on every event; window zero: same second only
        write_register(CFG_WINDOW, 17'd0);
        write_register(CFG_LIMIT, 17'd0);
        send_event(32'd50, 16'h0003, 16'h00AA, 1'b1);
        send_event(32'd50, 16'h0004, 16'h00AA, 1'b0);
        send_event(32'd51, 16'h0004, 16'h00AA, 1'b0);
        await_results();
    endtask

    task automatic test_truncated_history();
        int k;
        write_register(CFG_WINDOW, 17'd86400);
        write_register(CFG_SPARE_2, 17'h1FFFF);
        write_register(CFG_SPARE_3, 17'h00000);
        write_register(CFG_WINDOW, 17'h1FFFF);  // beyond a day, used as given
        write_register(CFG_LIMIT, 17'd15);
        // 17 distinct tags inside the window: cap reached, then ring overrun
        for (k = 0; k < HIST_DEPTH + 1; k++)
            send_event(32'd1000 + k, TAG_W'(16'h0010 + k), 16'h1234, k == 0);
        await_results();
    endtask

    task automatic test_back_to_back();
        int start;
        no_gaps = 1'b1;
        start   = events_sent;
        while (events_sent - start < 120)
            run_user_group($urandom_range(1, 20), 1'b1);
        await_results();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_groups(input int target);
        logic [CFG_DATA_W-1:0] win_val;
        logic [CFG_DATA_W-1:0] lim_val;
        int                    phase;
        int                    start;
        int                    len;
        phase = 0;
        while (events_sent < target) begin
            // settings change only once the block has drained
            await_results();
            case (phase)
                0: begin win_val = 17'd0;      lim_val = 17'd1;  end
                1: begin win_val = 17'd86400;  lim_val = 17'd15; end
                2: begin win_val = 17'h1FFFF;  lim_val = 17'd0;  end
                3: begin win_val = WINDOW_RESET; lim_val = CFG_DATA_W'(LIMIT_RESET); end
                default: begin
                    win_val = ($urandom_range(0, 1) == 0)
                              ? CFG_DATA_W'($urandom_range(0, 400))
                              : CFG_DATA_W'($urandom_range(0, 17'h1FFFF));
                    // upper bits beyond the limit field are dropped
                    lim_val = CFG_DATA_W'($urandom);
                end
            endcase
            write_register(CFG_WINDOW, win_val);
            write_register(CFG_LIMIT, lim_val);
            if ($urandom_range(0, 3) == 0)
                write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                               CFG_DATA_W'($urandom));
            start = events_sent;
            while (events_sent - start < 80 && events_sent < target) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24)
                                                  : $urandom_range(1, 12);
                run_user_group(len, $urandom_range(0, 9) != 0);
                if ($urandom_range(0, 19) == 0)
                    send_event($urandom, TAG_W'($urandom), USER_W'($urandom),
                               $urandom_range(0, 1) != 0);
                if ($urandom_range(0, 15) == 0)
                    await_results();
            end
            phase++;
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        no_gaps     = 1'b0;
        fault_count = 0;
        events_sent = 0;
        win_reg     = WINDOW_RESET;
        lim_reg     = LIMIT_RESET;
        ring_fill   = 0;
        ring_slot   = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_window();
        test_zero_limit_window();
        test_truncated_history();
        test_back_to_back();
        test_random_groups(EVENT_TARGET);

        await_results();
        repeat (40) @(posedge aclk);
        if (fault_count == 0 && pending_alarms.size() == 0)
            $display("PASS windowed_distinct_id_alarm_unit");
        else
            $display("FAIL windowed_distinct_id_alarm_unit");
        $finish;
    end

endmodule

[files.f]
rtl/wdia_pkg.sv
rtl/wdia_ctrl.sv
rtl/wdia_datapath.sv
rtl/windowed_distinct_id_alarm_unit.sv
test/tb.sv
